// File: rtl/cdh_pkg.sv
`default_nettype none

package cdh_pkg;

  // Table geometry. The slot count must be a power of two so that the hash
  // reduction and the probe wrap are plain bit truncations.
  localparam int TABLE_SIZE = 4096;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int NODE_W     = 13;
  localparam int COORD_W    = 32;
  localparam int KEY_W      = 2 * COORD_W;

  // Hash multipliers. Only their low slot bits reach the slot index.
  localparam logic [31:0] HASH_MUL_X = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
  localparam logic [SLOT_W-1:0] HASH_X_LOW = HASH_MUL_X[SLOT_W-1:0];
  localparam logic [SLOT_W-1:0] HASH_Y_LOW = HASH_MUL_Y[SLOT_W-1:0];

  // One chain point.
  typedef struct packed {
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic               chain_start;
    logic               chain_end;
  } point_t;

  // One lookup result.
  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic              is_new;
    logic [NODE_W-1:0] prev_node;
    logic              endpoint_valid;
    logic [NODE_W-1:0] endpoint_first;
    logic [NODE_W-1:0] endpoint_last;
    logic              table_full;
  } result_t;

  // One table entry: valid flag, packed coordinates and node number.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] node;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/cdh_ram.sv
`default_nettype none

module cdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cdh_hash.sv
`default_nettype none

module cdh_hash (
  input  logic                      clk,
  input  logic                      load,
  input  logic [cdh_pkg::SLOT_W-1:0] x_low,
  input  logic [cdh_pkg::SLOT_W-1:0] y_low,
  output logic [cdh_pkg::SLOT_W-1:0] pos
);

  logic [2*cdh_pkg::SLOT_W-1:0] prod_x;
  logic [2*cdh_pkg::SLOT_W-1:0] prod_y;

  // The low bits of a product depend only on the low bits of its factors,
  // so the full 64-bit hash reduced to the slot count needs only these.
  assign prod_x = x_low * cdh_pkg::HASH_X_LOW;
  assign prod_y = y_low * cdh_pkg::HASH_Y_LOW;

  // Register the home slot when a point transfer is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      pos <= prod_x[cdh_pkg::SLOT_W-1:0] ^ prod_y[cdh_pkg::SLOT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/coordinate_dedup_hash_table_core.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// point     in         point_valid / point_stall   cdh_pkg::point_t
// result    out        result_valid / result_stall cdh_pkg::result_t
//
// A point passes from its transfer through S_READ, which reads its home
// slot, and S_CHECK, once per slot probed (one table read per probe), to
// S_DONE, which loads its result. A new point is taken only in S_IDLE, so
// not before the previous point has loaded its result. A full table costs
// TABLE_SIZE probes. After reset a clearing pass writes every slot invalid,
// one per cycle; no point is taken during that pass.
// A stalled result holds the controller until it is taken, while the
// next point can already be taken once the controller is back at rest.

module coordinate_dedup_hash_table_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_stall,
  input  cdh_pkg::point_t  point,
  output logic             result_valid,
  input  logic             result_stall,
  output cdh_pkg::result_t result
);

  cdh_pkg::state_t state;
  cdh_pkg::state_t state_next;

  logic [cdh_pkg::SLOT_W-1:0] clear_addr;
  logic [cdh_pkg::SLOT_W-1:0] clear_addr_next;
  logic [cdh_pkg::SLOT_W-1:0] pos;
  logic [cdh_pkg::SLOT_W-1:0] probe;
  logic [cdh_pkg::SLOT_W-1:0] probe_next;
  logic [cdh_pkg::SLOT_W-1:0] probe_cnt;
  logic [cdh_pkg::SLOT_W-1:0] probe_cnt_next;

  logic [cdh_pkg::NODE_W-1:0] node_count;
  logic [cdh_pkg::NODE_W-1:0] node_count_next;
  logic [cdh_pkg::NODE_W-1:0] chain_prev;
  logic [cdh_pkg::NODE_W-1:0] chain_prev_next;
  logic [cdh_pkg::NODE_W-1:0] chain_first;
  logic [cdh_pkg::NODE_W-1:0] chain_first_next;

  cdh_pkg::point_t  item;
  cdh_pkg::result_t res;
  cdh_pkg::result_t res_next;
  cdh_pkg::result_t res_calc;

  logic                       ram_we;
  logic [cdh_pkg::SLOT_W-1:0] ram_waddr;
  cdh_pkg::slot_t             ram_wdata;
  logic                       ram_re;
  logic [cdh_pkg::SLOT_W-1:0] ram_raddr;
  cdh_pkg::slot_t             ram_rdata;

  logic point_take;
  logic result_load;

  logic                       hit_free;
  logic                       hit_key;
  logic                       last_probe;
  logic                       finish;
  logic                       full;
  logic [cdh_pkg::NODE_W-1:0] node_new;
  logic [cdh_pkg::NODE_W-1:0] node;
  logic [cdh_pkg::NODE_W-1:0] first0;
  logic [cdh_pkg::NODE_W-1:0] prev0;
  logic [cdh_pkg::NODE_W-1:0] first1;
  logic [cdh_pkg::NODE_W-1:0] prev1;
  logic                       ep_valid;

  assign point_stall = (state != cdh_pkg::S_IDLE);
  assign point_take  = point_valid && !point_stall;
  assign result_load = !result_valid || !result_stall;

  // Home slot of the incoming point.
  cdh_hash u_hash (
    .clk   (clk),
    .load  (point_take),
    .x_low (point.x_coord[cdh_pkg::SLOT_W-1:0]),
    .y_low (point.y_coord[cdh_pkg::SLOT_W-1:0]),
    .pos   (pos)
  );

  // Slot table: valid flag, key and node in one word.
  cdh_ram #(
    .WIDTH (cdh_pkg::SLOT_BITS),
    .DEPTH (cdh_pkg::TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Probe outcome for the slot whose data is on the read port.
  assign hit_free   = !ram_rdata.valid;
  assign hit_key    = ram_rdata.valid && (ram_rdata.key == {item.x_coord, item.y_coord});
  assign last_probe = (probe_cnt == cdh_pkg::SLOT_W'(cdh_pkg::TABLE_SIZE - 1));
  assign finish     = hit_free || hit_key || last_probe;
  assign full       = !hit_free && !hit_key;
  assign node_new   = node_count + cdh_pkg::NODE_W'(1);
  assign node       = hit_free ? node_new : (hit_key ? ram_rdata.node : '0);

  // Chain tracking. A start mark clears the chain before the point counts;
  // a point that could not be stored adds no node to the chain.
  assign first0   = item.chain_start ? '0 : chain_first;
  assign prev0    = item.chain_start ? '0 : chain_prev;
  assign first1   = full ? first0 : ((first0 == '0) ? node : first0);
  assign prev1    = full ? prev0 : node;
  assign ep_valid = item.chain_end && (first1 != '0) && (prev1 != '0) && (first1 != prev1);

  // Result word for a finished lookup.
  always_comb begin
    res_calc.node_id        = node;
    res_calc.is_new         = hit_free;
    res_calc.prev_node      = full ? '0 : prev0;
    res_calc.endpoint_valid = ep_valid;
    res_calc.endpoint_first = ep_valid ? first1 : '0;
    res_calc.endpoint_last  = ep_valid ? prev1 : '0;
    res_calc.table_full     = full;
  end

  // Next state, table accesses and state updates.
  always_comb begin
    state_next       = state;
    clear_addr_next  = clear_addr;
    probe_next       = probe;
    probe_cnt_next   = probe_cnt;
    node_count_next  = node_count;
    chain_prev_next  = chain_prev;
    chain_first_next = chain_first;
    res_next         = res;
    ram_we           = 1'b0;
    ram_waddr        = probe;
    ram_wdata        = '0;
    ram_re           = 1'b0;
    ram_raddr        = probe + cdh_pkg::SLOT_W'(1);
    unique case (state)
      cdh_pkg::S_CLEAR: begin
        ram_we          = 1'b1;
        ram_waddr       = clear_addr;
        clear_addr_next = clear_addr + cdh_pkg::SLOT_W'(1);
        if (clear_addr == cdh_pkg::SLOT_W'(cdh_pkg::TABLE_SIZE - 1)) begin
          state_next = cdh_pkg::S_IDLE;
        end
      end
      cdh_pkg::S_IDLE: begin
        if (point_take) begin
          state_next = cdh_pkg::S_READ;
        end
      end
      cdh_pkg::S_READ: begin
        ram_re         = 1'b1;
        ram_raddr      = pos;
        probe_next     = pos;
        probe_cnt_next = '0;
        state_next     = cdh_pkg::S_CHECK;
      end
      cdh_pkg::S_CHECK: begin
        if (finish) begin
          if (hit_free) begin
            ram_we          = 1'b1;
            ram_waddr       = probe;
            ram_wdata.valid = 1'b1;
            ram_wdata.key   = {item.x_coord, item.y_coord};
            ram_wdata.node  = node_new;
            node_count_next = node_new;
          end
          chain_first_next = item.chain_end ? '0 : first1;
          chain_prev_next  = item.chain_end ? '0 : prev1;
          res_next         = res_calc;
          state_next       = cdh_pkg::S_DONE;
        end else begin
          // Occupied by another key: read the following slot.
          ram_re         = 1'b1;
          probe_next     = probe + cdh_pkg::SLOT_W'(1);
          probe_cnt_next = probe_cnt + cdh_pkg::SLOT_W'(1);
        end
      end
      cdh_pkg::S_DONE: begin
        if (result_load) begin
          state_next = cdh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cdh_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cdh_pkg::S_CLEAR;
      clear_addr  <= '0;
      node_count  <= '0;
      chain_prev  <= '0;
      chain_first <= '0;
    end else begin
      state       <= state_next;
      clear_addr  <= clear_addr_next;
      node_count  <= node_count_next;
      chain_prev  <= chain_prev_next;
      chain_first <= chain_first_next;
    end
  end

  // Working registers of the current point.
  always_ff @(posedge clk) begin
    if (point_take) begin
      item <= point;
    end
    probe     <= probe_next;
    probe_cnt <= probe_cnt_next;
    res       <= res_next;
  end

  // Output register: loaded from the finished lookup, held while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == cdh_pkg::S_DONE) && result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == cdh_pkg::S_DONE) && result_load) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cdh_checker.sv
`default_nettype none

module cdh_checker (
  input logic             clk,
  input logic             rst,
  input logic             point_valid,
  input logic             point_stall,
  input logic             result_valid,
  input logic             result_stall,
  input cdh_pkg::result_t result
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // The controller works on one point at a time.
  assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_stall |=> point_stall)
    else $error("second point taken while a lookup is in progress");

  // A point that could not be stored gives no node and no link.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.table_full |->
      (result.node_id == '0) && !result.is_new && (result.prev_node == '0))
    else $error("full-table result carries a node");

  // A stored point that ends a chain is the chain's last endpoint.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.endpoint_valid && !result.table_full |->
      (result.endpoint_last == result.node_id) &&
      (result.endpoint_first != result.endpoint_last))
    else $error("endpoint pair does not match the closing node");

  // No result is shown right after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind coordinate_dedup_hash_table_core cdh_checker u_cdh_checker (.*);

`default_nettype wire
